// ===== sv/xcpd_pkg.sv =====
// Shared constants and controller/datapath interface types for the packet deframer.
package xcpd_pkg;

  localparam int DEFAULT_PAYLOAD_DEPTH = 16;

  localparam logic [7:0] START_BYTE = 8'h24;
  localparam logic [7:0] CR_BYTE    = 8'h0D;
  localparam logic [7:0] LF_BYTE    = 8'h0A;

  // result status codes
  localparam logic [2:0] ST_PAYLOAD   = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_TOO_LONG  = 3'd2;
  localparam logic [2:0] ST_BAD_SUM   = 3'd3;
  localparam logic [2:0] ST_BAD_CR    = 3'd4;
  localparam logic [2:0] ST_BAD_LF    = 3'd5;

  typedef struct packed {
    logic       take;
    logic       load_type;
    logic       load_len;
    logic       pay_write;
    logic       drain_start;
    logic       drain_next;
    logic       emit;
    logic [2:0] emit_code;
  } xcpd_cmd_t;

  typedef struct packed {
    logic rx_start;
    logic rx_too_long;
    logic rx_zero;
    logic pay_done;
    logic sum_ok;
    logic rx_cr;
    logic rx_lf;
    logic held_zero;
    logic drain_last;
    logic out_free;
  } xcpd_stat_t;

endpackage

// ===== sv/xcpd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module xcpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/xcpd_dp.sv =====
// Deframer datapath: frame header registers, checksum, payload store and result register.
module xcpd_dp
  import xcpd_pkg::*;
#(
  parameter int PAYLOAD_DEPTH = DEFAULT_PAYLOAD_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  xcpd_cmd_t  cmd,
  output xcpd_stat_t stat,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [2:0] status,
  output logic [7:0] frame_type,
  output logic [7:0] frame_length,
  output logic [7:0] payload_byte,
  output logic [5:0] payload_index,
  output logic [7:0] got_byte,
  output logic [7:0] expected_byte,
  output logic       last
);

  localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam int CW = $clog2(PAYLOAD_DEPTH + 1);

  logic [7:0]    held_type;
  logic [7:0]    held_length;
  logic [CW-1:0] count;
  logic [7:0]    running_xor;
  logic [AW-1:0] drain_idx;
  logic [7:0]    rd_data;

  xcpd_ram #(
    .WIDTH (8),
    .DEPTH (PAYLOAD_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (cmd.pay_write),
    .waddr (count[AW-1:0]),
    .wdata (rx_byte),
    .raddr (drain_idx),
    .rdata (rd_data)
  );

  always_comb begin
    stat.rx_start    = (rx_byte == START_BYTE);
    stat.rx_too_long = (rx_byte > 8'(PAYLOAD_DEPTH));
    stat.rx_zero     = (rx_byte == 8'd0);
    stat.pay_done    = ((8'(count) + 8'd1) >= held_length);
    stat.sum_ok      = (rx_byte == running_xor);
    stat.rx_cr       = (rx_byte == CR_BYTE);
    stat.rx_lf       = (rx_byte == LF_BYTE);
    stat.held_zero   = (held_length == 8'd0);
    stat.drain_last  = ((8'(drain_idx) + 8'd1) == held_length);
    stat.out_free    = !res_valid || !res_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_type   <= 8'd0;
      held_length <= 8'd0;
      count       <= '0;
      running_xor <= 8'd0;
      drain_idx   <= '0;
    end else begin
      if (cmd.load_type) begin
        held_type <= rx_byte;
      end
      if (cmd.load_len) begin
        held_length <= rx_byte;
        count       <= '0;
        running_xor <= 8'd0;
      end else if (cmd.pay_write) begin
        count       <= count + CW'(1);
        running_xor <= running_xor ^ rx_byte;
      end
      if (cmd.drain_start) begin
        drain_idx <= '0;
      end else if (cmd.drain_next) begin
        drain_idx <= drain_idx + AW'(1);
      end
    end
  end

  // result register; loaded only when the controller sees it free
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status        <= cmd.emit_code;
      frame_type    <= held_type;
      frame_length  <= cmd.load_len ? rx_byte : held_length;
      payload_byte  <= 8'd0;
      payload_index <= 6'd0;
      got_byte      <= 8'd0;
      expected_byte <= 8'd0;
      last          <= 1'b1;
      case (cmd.emit_code)
        ST_PAYLOAD: begin
          payload_byte  <= rd_data;
          payload_index <= 6'(drain_idx);
          last          <= stat.drain_last;
        end
        ST_BAD_SUM: begin
          got_byte      <= rx_byte;
          expected_byte <= running_xor;
        end
        ST_BAD_CR: begin
          got_byte      <= rx_byte;
          expected_byte <= CR_BYTE;
        end
        ST_BAD_LF: begin
          got_byte      <= rx_byte;
          expected_byte <= LF_BYTE;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== sv/xcpd_ctrl.sv =====
// Deframer controller: frame parsing state machine and payload drain sequencing.
module xcpd_ctrl
  import xcpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  xcpd_stat_t stat,
  output xcpd_cmd_t  cmd
);

  localparam logic [3:0] S_HUNT0 = 4'd0;
  localparam logic [3:0] S_HUNT1 = 4'd1;
  localparam logic [3:0] S_TYPE  = 4'd2;
  localparam logic [3:0] S_LEN   = 4'd3;
  localparam logic [3:0] S_PAY   = 4'd4;
  localparam logic [3:0] S_SUM   = 4'd5;
  localparam logic [3:0] S_CR    = 4'd6;
  localparam logic [3:0] S_LF    = 4'd7;
  localparam logic [3:0] S_RD    = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       draining;

  assign draining = (state == S_RD) || (state == S_EMIT);
  assign rx_stall = draining || !stat.out_free;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.take    = rx_valid && !rx_stall;
    case (state)
      S_HUNT0: begin
        if (cmd.take && stat.rx_start) begin
          state_next = S_HUNT1;
        end
      end
      S_HUNT1: begin
        if (cmd.take) begin
          state_next = stat.rx_start ? S_TYPE : S_HUNT0;
        end
      end
      S_TYPE: begin
        if (cmd.take) begin
          cmd.load_type = 1'b1;
          state_next    = S_LEN;
        end
      end
      S_LEN: begin
        if (cmd.take) begin
          cmd.load_len = 1'b1;
          if (stat.rx_too_long) begin
            cmd.emit      = 1'b1;
            cmd.emit_code = ST_TOO_LONG;
            state_next    = S_HUNT0;
          end else if (stat.rx_zero) begin
            state_next = S_SUM;
          end else begin
            state_next = S_PAY;
          end
        end
      end
      S_PAY: begin
        if (cmd.take) begin
          cmd.pay_write = 1'b1;
          if (stat.pay_done) begin
            state_next = S_SUM;
          end
        end
      end
      S_SUM: begin
        if (cmd.take) begin
          if (stat.sum_ok) begin
            state_next = S_CR;
          end else begin
            cmd.emit      = 1'b1;
            cmd.emit_code = ST_BAD_SUM;
            state_next    = S_HUNT0;
          end
        end
      end
      S_CR: begin
        if (cmd.take) begin
          if (stat.rx_cr) begin
            state_next = S_LF;
          end else begin
            cmd.emit      = 1'b1;
            cmd.emit_code = ST_BAD_CR;
            state_next    = S_HUNT0;
          end
        end
      end
      S_LF: begin
        if (cmd.take) begin
          state_next = S_HUNT0;
          if (!stat.rx_lf) begin
            cmd.emit      = 1'b1;
            cmd.emit_code = ST_BAD_LF;
          end else if (stat.held_zero) begin
            cmd.emit      = 1'b1;
            cmd.emit_code = ST_EMPTY;
          end else begin
            cmd.drain_start = 1'b1;
            state_next      = S_RD;
          end
        end
      end
      S_RD: begin
        // store read address settles this cycle, data is valid in S_EMIT
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_code = ST_PAYLOAD;
          if (stat.drain_last) begin
            state_next = S_HUNT0;
          end else begin
            cmd.drain_next = 1'b1;
            state_next     = S_RD;
          end
        end
      end
      default: begin
        state_next = S_HUNT0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_HUNT0;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/xor_checked_packet_deframer_core.sv =====
// An error or empty-frame result is in the result register in the cycle after its byte is taken.
// Throughput: one received byte per cycle while parsing; input stalls while the result
//   register is full and stalled.
// After a good LF of a non-empty frame the payload drains from the store byte by byte (store
//   read, then result load), and input is held off until the last byte is loaded.
// Reset (rst, synchronous) returns the parser to start-byte hunt; the payload store is not cleared.
module xor_checked_packet_deframer_core
  import xcpd_pkg::*;
#(
  parameter int PAYLOAD_DEPTH = DEFAULT_PAYLOAD_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [2:0] status,
  output logic [7:0] frame_type,
  output logic [7:0] frame_length,
  output logic [7:0] payload_byte,
  output logic [5:0] payload_index,
  output logic [7:0] got_byte,
  output logic [7:0] expected_byte,
  output logic       last
);

  xcpd_cmd_t  cmd;
  xcpd_stat_t stat;

  xcpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_stall (rx_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  xcpd_dp #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .rx_byte       (rx_byte),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .status        (status),
    .frame_type    (frame_type),
    .frame_length  (frame_length),
    .payload_byte  (payload_byte),
    .payload_index (payload_index),
    .got_byte      (got_byte),
    .expected_byte (expected_byte),
    .last          (last)
  );

`ifndef SYNTHESIS
  // a full, stalled result register must hold off new bytes
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |-> rx_stall)
    else $error("byte taken while result register blocked");

  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (status <= ST_BAD_LF))
    else $error("undefined status code");

  assert property (@(posedge clk) disable iff (rst)
    (res_valid && (status != ST_PAYLOAD)) |-> last)
    else $error("error or empty result without last");

  assert property (@(posedge clk) disable iff (rst)
    (res_valid && (status == ST_PAYLOAD)) |->
      ((7'(payload_index) < 7'(PAYLOAD_DEPTH)) && (8'(payload_index) < frame_length)))
    else $error("payload index out of frame");
`endif

endmodule

// ===== verif/xor_checked_packet_deframer_core_test.sv =====
// Self-checking testbench for the checked packet deframer core.
`timescale 1ns / 1ps

module xor_checked_packet_deframer_core_test
  import xcpd_pkg::*;
();

  localparam int DEPTH        = DEFAULT_PAYLOAD_DEPTH;
  localparam int RANDOM_BYTES = 125;
  localparam int HOLD_CYCLES  = 150;
  localparam int TAIL_CYCLES  = 2 * DEPTH + 20;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int QUIET_BYTES  = 40;

  typedef enum logic [2:0] {
    HUNT_FIRST, HUNT_SECOND, GET_TYPE, GET_LEN, GET_PAYLOAD, GET_SUM, GET_CR, GET_LF
  } parse_phase_e;

  typedef enum int { FLAW_NONE, FLAW_SUM, FLAW_CR, FLAW_LF, FLAW_CUT } frame_flaw_e;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] frame_type;
    logic [7:0] frame_length;
    logic [7:0] payload_byte;
    logic [5:0] payload_index;
    logic [7:0] got_byte;
    logic [7:0] expected_byte;
    logic       last;
  } frame_result_t;

  class deframe_scoreboard;
    parse_phase_e  phase;
    bit [7:0]      held_type;
    bit [7:0]      held_length;
    bit [6:0]      rcv_count;
    bit [7:0]      run_xor;
    bit [7:0]      payload_mem [DEPTH];
    frame_result_t results_due [$];
    int unsigned   bad_count;

    function new();
      phase       = HUNT_FIRST;
      held_type   = '0;
      held_length = '0;
      rcv_count   = '0;
      run_xor     = '0;
      bad_count   = 0;
    endfunction

    function int pending();
      return results_due.size();
    endfunction

    function void add_result(logic [2:0] st, logic [7:0] pbyte, logic [5:0] pidx,
                             logic [7:0] got, logic [7:0] want, logic fin);
      frame_result_t r;
      r.status        = st;
      r.frame_type    = held_type;
      r.frame_length  = held_length;
      r.payload_byte  = pbyte;
      r.payload_index = pidx;
      r.got_byte      = got;
      r.expected_byte = want;
      r.last          = fin;
      results_due.push_back(r);
    endfunction

    // advance the parser by one accepted byte and queue whatever it releases
    function void note_byte(bit [7:0] b);
      int i;
      case (phase)
        HUNT_FIRST:  phase = (b == START_BYTE) ? HUNT_SECOND : HUNT_FIRST;
        HUNT_SECOND: phase = (b == START_BYTE) ? GET_TYPE : HUNT_FIRST;
        GET_TYPE: begin
          held_type = b;
          phase = GET_LEN;
        end
        GET_LEN: begin
          held_length = b;
          rcv_count = '0;
          run_xor = '0;
          if (b > DEPTH) begin
            add_result(ST_TOO_LONG, 8'h00, 6'd0, 8'h00, 8'h00, 1'b1);
            phase = HUNT_FIRST;
          end else if (b == 0) begin
            phase = GET_SUM;
          end else begin
            phase = GET_PAYLOAD;
          end
        end
        GET_PAYLOAD: begin
          run_xor ^= b;
          if (rcv_count < DEPTH) payload_mem[rcv_count] = b;
          rcv_count = rcv_count + 7'd1;
          if (rcv_count >= held_length) phase = GET_SUM;
        end
        GET_SUM: begin
          if (b == run_xor) begin
            phase = GET_CR;
          end else begin
            add_result(ST_BAD_SUM, 8'h00, 6'd0, b, run_xor, 1'b1);
            phase = HUNT_FIRST;
          end
        end
        GET_CR: begin
          if (b == CR_BYTE) begin
            phase = GET_LF;
          end else begin
            add_result(ST_BAD_CR, 8'h00, 6'd0, b, CR_BYTE, 1'b1);
            phase = HUNT_FIRST;
          end
        end
        default: begin
          if (b != LF_BYTE) begin
            add_result(ST_BAD_LF, 8'h00, 6'd0, b, LF_BYTE, 1'b1);
          end else if (held_length == 0) begin
            add_result(ST_EMPTY, 8'h00, 6'd0, 8'h00, 8'h00, 1'b1);
          end else begin
            for (i = 0; i < held_length; i++)
              add_result(ST_PAYLOAD, payload_mem[i], 6'(i), 8'h00, 8'h00,
                         (i + 1 == held_length));
          end
          phase = HUNT_FIRST;
        end
      endcase
    endfunction

    function string fmt(frame_result_t r);
      return $sformatf("st=%0d type=%02h len=%0d byte=%02h idx=%0d got=%02h exp=%02h last=%0b",
                       r.status, r.frame_type, r.frame_length, r.payload_byte,
                       r.payload_index, r.got_byte, r.expected_byte, r.last);
    endfunction

    function void flag(string what, string want_txt, frame_result_t seen);
      bad_count++;
      if (bad_count <= 10)
        $display("%0t: %s: expected %s, actual %s", $realtime, what, want_txt, fmt(seen));
    endfunction

    function void check_result(frame_result_t seen);
      frame_result_t want;
      if (results_due.size() == 0) begin
        flag("unexpected result", "nothing", seen);
        return;
      end
      want = results_due.pop_front();
      if (seen.status !== want.status || seen.frame_type !== want.frame_type ||
          seen.frame_length !== want.frame_length ||
          seen.payload_byte !== want.payload_byte ||
          seen.payload_index !== want.payload_index ||
          seen.got_byte !== want.got_byte || seen.expected_byte !== want.expected_byte ||
          seen.last !== want.last)
        flag("result mismatch", fmt(want), seen);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       rx_valid = 1'b0;
  logic       rx_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       res_valid;
  logic       res_stall = 1'b0;
  logic [2:0] status;
  logic [7:0] frame_type;
  logic [7:0] frame_length;
  logic [7:0] payload_byte;
  logic [5:0] payload_index;
  logic [7:0] got_byte;
  logic [7:0] expected_byte;
  logic       last;

  deframe_scoreboard scoreboard;
  bit [7:0]          byte_plan [$];
  bit                hold_req = 1'b0;
  bit                wind_down = 1'b0;
  int unsigned       cycle_count = 0;

  xor_checked_packet_deframer_core #(
    .PAYLOAD_DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .rx_valid(rx_valid),
    .rx_stall(rx_stall),
    .rx_byte(rx_byte),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .status(status),
    .frame_type(frame_type),
    .frame_length(frame_length),
    .payload_byte(payload_byte),
    .payload_index(payload_index),
    .got_byte(got_byte),
    .expected_byte(expected_byte),
    .last(last)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  task automatic plan_byte(bit [7:0] b);
    byte_plan.push_back(b);
  endtask

  // fill < 0 gives random payload bytes, else every payload byte is fill
  task automatic plan_frame(bit [7:0] ftype, int len, int fill, frame_flaw_e flaw);
    bit [7:0] sum;
    bit [7:0] pb;
    int       count;
    int       i;
    sum = 8'h00;
    plan_byte(START_BYTE);
    plan_byte(START_BYTE);
    plan_byte(ftype);
    plan_byte(len[7:0]);
    if (len > DEPTH) return;
    count = (flaw == FLAW_CUT) ? len / 2 : len;
    for (i = 0; i < count; i++) begin
      pb = (fill < 0) ? 8'($urandom) : fill[7:0];
      sum ^= pb;
      plan_byte(pb);
    end
    if (flaw == FLAW_CUT) return;
    plan_byte((flaw == FLAW_SUM) ? sum ^ 8'($urandom_range(1, 255)) : sum);
    plan_byte((flaw == FLAW_CR) ? CR_BYTE ^ 8'($urandom_range(1, 255)) : CR_BYTE);
    plan_byte((flaw == FLAW_LF) ? LF_BYTE ^ 8'($urandom_range(1, 255)) : LF_BYTE);
  endtask

  task automatic plan_directed();
    plan_frame(8'h00, 0, -1, FLAW_NONE);
    plan_frame(8'hFF, 1, 255, FLAW_NONE);
    plan_frame(8'h81, DEPTH, -1, FLAW_NONE);
    // a non-start byte after one '$' drops back to the hunt
    plan_byte(START_BYTE);
    plan_byte(8'hA5);
    plan_byte(8'h00);
    plan_frame(START_BYTE, 1, 0, FLAW_NONE);
    plan_frame(8'h3C, DEPTH + 1, -1, FLAW_NONE);
    plan_frame(8'hC3, 255, -1, FLAW_NONE);
    plan_frame(8'h11, 0, -1, FLAW_SUM);
    plan_frame(8'h22, 2, 0, FLAW_CR);
    plan_frame(8'h44, 3, -1, FLAW_LF);
  endtask

  task automatic plan_random();
    int stop_at;
    int pick;
    int len;
    int n;
    stop_at = byte_plan.size() + RANDOM_BYTES;
    while (byte_plan.size() < stop_at) begin
      pick = $urandom_range(0, 19);
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, DEPTH) : $urandom_range(0, 5);
      case (pick)
        13: plan_frame(8'($urandom), len, -1, FLAW_SUM);
        14: plan_frame(8'($urandom), len, -1, FLAW_CR);
        15: plan_frame(8'($urandom), len, -1, FLAW_LF);
        16: plan_frame(8'($urandom), $urandom_range(DEPTH + 1, 255), -1, FLAW_NONE);
        17: begin
          n = $urandom_range(1, 4);
          repeat (n) plan_byte(8'($urandom));
        end
        18: begin
          plan_byte(START_BYTE);
          plan_byte(START_BYTE ^ 8'($urandom_range(1, 255)));
        end
        19: plan_frame(8'($urandom), len, -1, FLAW_CUT);
        default: plan_frame(8'($urandom), len, -1, FLAW_NONE);
      endcase
    end
  endtask

  task automatic send_plan();
    int idx;
    int calm;
    int gap;
    idx = 0;
    calm = 0;
    while (idx < byte_plan.size()) begin
      if (idx == byte_plan.size() / 2) hold_req = 1'b1;
      if (idx >= byte_plan.size() - QUIET_BYTES) wind_down = 1'b1;
      if (!wind_down && calm == 0 && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 19);
        rx_valid <= 1'b0;
        repeat (gap) @(posedge clk);
        if ($urandom_range(0, 2) == 0) calm = $urandom_range(10, 40);
      end else if (calm > 0) begin
        calm--;
      end
      rx_valid <= 1'b1;
      rx_byte  <= byte_plan[idx];
      do @(posedge clk); while (rx_stall);
      scoreboard.note_byte(byte_plan[idx]);
      idx++;
    end
    rx_valid <= 1'b0;
  endtask

  // result side stall pattern, plus one long hold so the input backs up
  initial begin : result_side
    int calm;
    int span;
    calm = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        res_stall <= 1'b0;
      end else if (!wind_down && calm == 0 && $urandom_range(0, 7) == 0) begin
        span = $urandom_range(1, 19);
        res_stall <= 1'b1;
        repeat (span) @(posedge clk);
        res_stall <= 1'b0;
        if ($urandom_range(0, 2) == 0) calm = $urandom_range(20, 80);
      end else if (calm > 0) begin
        calm--;
      end
    end
  end

  always @(posedge clk) begin : result_watch
    frame_result_t seen;
    if (!rst && res_valid && !res_stall) begin
      seen.status        = status;
      seen.frame_type    = frame_type;
      seen.frame_length  = frame_length;
      seen.payload_byte  = payload_byte;
      seen.payload_index = payload_index;
      seen.got_byte      = got_byte;
      seen.expected_byte = expected_byte;
      seen.last          = last;
      scoreboard.check_result(seen);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : main_flow
    scoreboard = new();
    plan_directed();
    plan_random();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    send_plan();
    while (scoreboard.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (scoreboard.bad_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
